>>> rtl/xsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xsc_pkg: shared constants and helpers for the XML syntax color lexer
// Character codes, color codes, sizes and character class functions.
// ----------------------------------------------------------------------------
package xsc_pkg;

  localparam int CharBits     = 21;
  localparam int PosPortBits  = 32;
  localparam int OffsetBits   = 32;
  localparam int PositionBitsDefault = 32;
  localparam int ResDepth     = 4;

  // colors
  localparam logic [1:0] ColorText    = 2'd0;
  localparam logic [1:0] ColorMarkup  = 2'd1;
  localparam logic [1:0] ColorValue   = 2'd2;
  localparam logic [1:0] ColorComment = 2'd3;

  // characters
  localparam logic [CharBits-1:0] ChEnd    = 21'd0;
  localparam logic [CharBits-1:0] ChTab    = 21'd9;
  localparam logic [CharBits-1:0] ChLf     = 21'd10;
  localparam logic [CharBits-1:0] ChCr     = 21'd13;
  localparam logic [CharBits-1:0] ChSpace  = 21'd32;
  localparam logic [CharBits-1:0] ChDquote = 21'd34;
  localparam logic [CharBits-1:0] ChSquote = 21'd39;
  localparam logic [CharBits-1:0] ChLt     = 21'd60;
  localparam logic [CharBits-1:0] ChSlash  = 21'd47;
  localparam logic [CharBits-1:0] ChQuest  = 21'd63;
  localparam logic [CharBits-1:0] ChBang   = 21'd33;
  localparam logic [CharBits-1:0] ChDash   = 21'd45;
  localparam logic [CharBits-1:0] ChLbrack = 21'd91;
  localparam logic [CharBits-1:0] ChRbrack = 21'd93;
  localparam logic [CharBits-1:0] ChGt     = 21'd62;
  localparam logic [CharBits-1:0] ChEq     = 21'd61;
  localparam logic [CharBits-1:0] ChUscore = 21'd95;
  localparam logic [CharBits-1:0] ChColon  = 21'd58;
  localparam logic [CharBits-1:0] ChDig0   = 21'd48;
  localparam logic [CharBits-1:0] ChDig9   = 21'd57;
  localparam logic [CharBits-1:0] ChUpA    = 21'd65;
  localparam logic [CharBits-1:0] ChUpZ    = 21'd90;
  localparam logic [CharBits-1:0] ChLoA    = 21'd97;
  localparam logic [CharBits-1:0] ChLoZ    = 21'd122;

  localparam logic [2:0] CdataLastIdx = 3'd5;

  function automatic logic name_first(logic [CharBits-1:0] c);
    return (c >= ChUpA && c <= ChUpZ) || (c >= ChLoA && c <= ChLoZ) ||
           c == ChUscore || c == ChColon;
  endfunction

  function automatic logic name_next(logic [CharBits-1:0] c);
    return name_first(c) || (c >= ChDig0 && c <= ChDig9) || c == ChDash;
  endfunction

  function automatic logic is_space(logic [CharBits-1:0] c);
    return c == ChTab || c == ChLf || c == ChCr || c == ChSpace;
  endfunction

  // letters of the "CDATA[" keyword
  function automatic logic [CharBits-1:0] cdata_char(logic [2:0] idx);
    logic [CharBits-1:0] ch;
    case (idx)
      3'd0: ch = 21'd67;   // C
      3'd1: ch = 21'd68;   // D
      3'd2: ch = 21'd65;   // A
      3'd3: ch = 21'd84;   // T
      3'd4: ch = 21'd65;   // A
      3'd5: ch = ChLbrack;
      default: ch = ChEnd;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

>>> rtl/xml_syntax_color_lexer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xml_syntax_color_lexer: color-change events for XML syntax highlighting
// Path: a beat passes the input register, then the lexer step writes its
//   results into the result queue, whose head drives the output ports.
// Throughput: one character per cycle while the queue has room; set by the
//   result port, one result per cycle unless stalled, so two-result items slow it.
// Reset: asynchronous, clears the input and result queues and puts the
//   lexer in text mode with all flags and counters at zero.
// ----------------------------------------------------------------------------
module xml_syntax_color_lexer #(
  parameter int POSITION_BITS = xsc_pkg::PositionBitsDefault
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [xsc_pkg::CharBits-1:0]       char_code_i,
  input  wire logic [xsc_pkg::OffsetBits-1:0]     char_offset_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [1:0]                              color_o,
  output logic [xsc_pkg::PosPortBits-1:0]         position_o,
  output logic                                    is_error_o,
  output logic                                    last_of_item_o
);

  // Positions wrap at 2^PosW (POSITION_BITS capped at the port width) and are never wider than the port.
  localparam int PosW  = (POSITION_BITS < xsc_pkg::PosPortBits) ?
                         POSITION_BITS : xsc_pkg::PosPortBits;
  localparam int PtrW  = $clog2(xsc_pkg::ResDepth);
  localparam int CntW  = $clog2(xsc_pkg::ResDepth + 1);

  typedef enum logic [4:0] {
    ModeText, ModeLt, ModeBang, ModeBangDash, ModeCdataKw, ModeComment,
    ModeCdata, ModeStopFirst, ModeStopName, ModeStopSpace,
    // tag / instruction group; is_pi selects which one
    ModeNameFirst, ModeName, ModeAspace, ModeAname, ModeEq, ModeVwait,
    ModeValue, ModeEnd
  } mode_e;

  typedef struct packed {
    logic [1:0]      color;
    logic [PosW-1:0] position;
    logic            is_error;
    logic            last;
  } res_t;

  typedef struct packed {
    mode_e           mode;
    logic            is_pi;
    logic [PosW-1:0] mstart;      // offset of the current '<'
    logic            quote;       // 1: single quote
    logic            saw_space;
    logic [2:0]      prog;        // dashes, brackets or keyword letters
    logic            stopped;
  } lex_t;

  typedef struct packed {
    lex_t       st;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
    logic       again;            // same character is handled once more
  } ctx_t;

  // --------------------------------------------------------------------------
  // Lexer step helpers
  // --------------------------------------------------------------------------
  function automatic ctx_t emit(ctx_t x, logic [1:0] col, logic [PosW-1:0] pos,
                                logic err);
    ctx_t y;
    res_t r;
    y          = x;
    r.color    = col;
    r.position = pos;
    r.is_error = err;
    r.last     = 1'b0;
    case (x.n)
      2'd0: begin
        y.r0 = r;
        y.n  = 2'd1;
      end
      2'd1: begin
        y.r1 = r;
        y.n  = 2'd2;
      end
      default: y = x;
    endcase
    return y;
  endfunction

  function automatic ctx_t fail(ctx_t x, logic [PosW-1:0] off);
    ctx_t y;
    y            = emit(x, xsc_pkg::ColorText, off, 1'b1);
    y.st.stopped = 1'b1;
    y.st.mode    = ModeText;
    return y;
  endfunction

  // One handling of character c in the current mode.
  function automatic ctx_t lex_handle(ctx_t x, logic [xsc_pkg::CharBits-1:0] c,
                                      logic [PosW-1:0] off, logic [PosW-1:0] off1,
                                      logic [PosW-1:0] offm2);
    ctx_t y;
    logic pi;
    y       = x;
    y.again = 1'b0;
    pi      = x.st.is_pi;
    case (x.st.mode)
      ModeLt: begin
        if (c == xsc_pkg::ChSlash) begin
          y = emit(y, xsc_pkg::ColorMarkup, x.st.mstart, 1'b0);
          y.st.mode = ModeStopFirst;
        end else if (c == xsc_pkg::ChQuest) begin
          y = emit(y, xsc_pkg::ColorMarkup, x.st.mstart, 1'b0);
          y.st.mode  = ModeNameFirst;
          y.st.is_pi = 1'b1;
        end else if (c == xsc_pkg::ChBang) begin
          y.st.mode = ModeBang;
        end else begin
          y = emit(y, xsc_pkg::ColorMarkup, x.st.mstart, 1'b0);
          y.st.mode  = ModeNameFirst;
          y.st.is_pi = 1'b0;
          y.again    = 1'b1;
        end
      end
      ModeBang: begin
        if (c == xsc_pkg::ChDash) begin
          y.st.mode = ModeBangDash;
        end else if (c == xsc_pkg::ChLbrack) begin
          y.st.mode = ModeCdataKw;
          y.st.prog = 3'd0;
        end else begin
          y = fail(y, off);
        end
      end
      ModeBangDash: begin
        if (c == xsc_pkg::ChDash) begin
          y = emit(y, xsc_pkg::ColorComment, x.st.mstart, 1'b0);
          y.st.mode = ModeComment;
          y.st.prog = 3'd0;
        end else begin
          y = fail(y, off);
        end
      end
      ModeCdataKw: begin
        if (x.st.prog > xsc_pkg::CdataLastIdx || c != xsc_pkg::cdata_char(x.st.prog)) begin
          y = fail(y, off);
        end else if (x.st.prog == xsc_pkg::CdataLastIdx) begin
          y = emit(y, xsc_pkg::ColorMarkup, x.st.mstart, 1'b0);
          y = emit(y, xsc_pkg::ColorText, off1, 1'b0);
          y.st.mode = ModeCdata;
          y.st.prog = 3'd0;
        end else begin
          y.st.prog = x.st.prog + 3'd1;
        end
      end
      ModeComment, ModeCdata: begin
        if (c == xsc_pkg::ChEnd) begin
          y = emit(y, xsc_pkg::ColorText, off, 1'b0);
          y.st.mode = ModeText;
        end else if ((x.st.mode == ModeComment && c == xsc_pkg::ChDash) ||
                     (x.st.mode == ModeCdata && c == xsc_pkg::ChRbrack)) begin
          if (x.st.prog < 3'd2) y.st.prog = x.st.prog + 3'd1;
        end else if (c == xsc_pkg::ChGt && x.st.prog >= 3'd2) begin
          if (x.st.mode == ModeCdata) y = emit(y, xsc_pkg::ColorMarkup, offm2, 1'b0);
          y = emit(y, xsc_pkg::ColorText, off1, 1'b0);
          y.st.mode = ModeText;
          y.st.prog = 3'd0;
        end else begin
          y.st.prog = 3'd0;
        end
      end
      ModeStopFirst: begin
        if (xsc_pkg::name_first(c)) y.st.mode = ModeStopName;
        else y = fail(y, off);
      end
      ModeStopName: begin
        if (!xsc_pkg::name_next(c)) begin
          y.st.mode = ModeStopSpace;
          y.again   = 1'b1;
        end
      end
      ModeStopSpace: begin
        if (!xsc_pkg::is_space(c)) begin
          if (c == xsc_pkg::ChGt) begin
            y = emit(y, xsc_pkg::ColorText, off1, 1'b0);
            y.st.mode = ModeText;
          end else begin
            y = fail(y, off);
          end
        end
      end
      ModeNameFirst: begin
        if (xsc_pkg::name_first(c)) y.st.mode = ModeName;
        else y = fail(y, off);
      end
      ModeName: begin
        if (!xsc_pkg::name_next(c)) begin
          y.st.saw_space = 1'b0;
          y.st.mode      = ModeAspace;
          y.again        = 1'b1;
        end
      end
      ModeAname: begin
        if (!xsc_pkg::name_next(c)) begin
          y.st.mode = ModeEq;
          y.again   = 1'b1;
        end
      end
      ModeAspace: begin
        if (xsc_pkg::is_space(c)) begin
          y.st.saw_space = 1'b1;
        end else if (pi && c == xsc_pkg::ChQuest) begin
          y.st.mode = ModeEnd;
        end else if (!pi && c == xsc_pkg::ChSlash) begin
          y.st.mode = ModeEnd;
        end else if (!pi && c == xsc_pkg::ChGt) begin
          y = emit(y, xsc_pkg::ColorText, off1, 1'b0);
          y.st.mode = ModeText;
        end else if (c != xsc_pkg::ChEnd && x.st.saw_space && xsc_pkg::name_first(c)) begin
          y.st.mode = ModeAname;
        end else begin
          y = fail(y, off);
        end
      end
      ModeEq: begin
        if (!xsc_pkg::is_space(c)) begin
          if (c == xsc_pkg::ChEq) y.st.mode = ModeVwait;
          else y = fail(y, off);
        end
      end
      ModeVwait: begin
        if (!xsc_pkg::is_space(c)) begin
          if (c == xsc_pkg::ChDquote || c == xsc_pkg::ChSquote) begin
            y = emit(y, xsc_pkg::ColorValue, off, 1'b0);
            y.st.quote = (c == xsc_pkg::ChSquote);
            y.st.mode  = ModeValue;
          end else begin
            y = fail(y, off);
          end
        end
      end
      ModeValue: begin
        if (c == (x.st.quote ? xsc_pkg::ChSquote : xsc_pkg::ChDquote)) begin
          y = emit(y, xsc_pkg::ColorMarkup, off1, 1'b0);
          y.st.saw_space = 1'b0;
          y.st.mode      = ModeAspace;
        end else if (c == xsc_pkg::ChEnd) begin
          y = fail(y, off);
        end
      end
      ModeEnd: begin
        if (c == xsc_pkg::ChGt) begin
          y = emit(y, xsc_pkg::ColorText, off1, 1'b0);
          y.st.mode = ModeText;
        end else begin
          y = fail(y, off);
        end
      end
      default: begin
        // text mode
        if (c == xsc_pkg::ChLt) begin
          y.st.mstart = off;
          y.st.mode   = ModeLt;
        end else begin
          y.st.mode = ModeText;
        end
      end
    endcase
    return y;
  endfunction

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic                              in_vld_q, in_vld_d;
  logic [xsc_pkg::CharBits-1:0]      char_q;
  logic [xsc_pkg::OffsetBits-1:0]    off_q;
  logic                              in_fire;
  logic                              proc_go;

  // Result queue
  res_t              res_mem_q [xsc_pkg::ResDepth];
  logic [PtrW-1:0]   head_q, head_d;
  logic [PtrW-1:0]   tail_q, tail_d;
  logic [PtrW-1:0]   tail_nxt;
  logic [CntW-1:0]   count_q, count_d;
  logic              pop;

  // Lexer state
  lex_t              st_q, st_d;
  ctx_t              ctx0, ctx1, ctx2, ctx_f;
  logic [PosW-1:0]   off_p, off_p1, off_m2;
  res_t              head_res;

  // The step runs only when the queue has room for two results; the stall
  // looks at registered state only, never at out_stall_i.
  assign proc_go    = in_vld_q && (count_q <= CntW'(xsc_pkg::ResDepth - 2));
  assign in_stall_o = in_vld_q && !proc_go;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_fire || (in_vld_q && !proc_go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      char_q <= char_code_i;
      off_q  <= char_offset_i;
    end
  end

  // --------------------------------------------------------------------------
  // Lexer step: at most two handlings of the same character
  // --------------------------------------------------------------------------
  assign off_p  = off_q[PosW-1:0];
  assign off_p1 = off_p + PosW'(1);
  assign off_m2 = off_p - PosW'(2);

  always_comb begin
    ctx0       = '0;
    ctx0.st    = st_q;
    ctx1       = ctx0;
    ctx2       = ctx0;
    if (!st_q.stopped) begin
      ctx1 = lex_handle(ctx0, char_q, off_p, off_p1, off_m2);
      ctx2 = ctx1;
      // a mode that hands the character on never hands it on twice
      if (ctx1.again && !ctx1.st.stopped) begin
        ctx2 = lex_handle(ctx1, char_q, off_p, off_p1, off_m2);
      end
    end
    ctx_f = ctx2;
    // end of text clears the stop and returns to text mode
    if (char_q == xsc_pkg::ChEnd) begin
      ctx_f.st.stopped   = 1'b0;
      ctx_f.st.mode      = ModeText;
      ctx_f.st.prog      = 3'd0;
      ctx_f.st.saw_space = 1'b0;
    end
    if (ctx_f.n == 2'd1) ctx_f.r0.last = 1'b1;
    if (ctx_f.n == 2'd2) ctx_f.r1.last = 1'b1;
    st_d = proc_go ? ctx_f.st : st_q;
  end

  // all-zero state is text mode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue: up to two writes per step, one read per cycle
  // --------------------------------------------------------------------------
  assign pop      = out_valid_o && !out_stall_i;
  assign tail_nxt = tail_q + PtrW'(1);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (pop) head_d = head_q + PtrW'(1);
    if (proc_go) tail_d = tail_q + PtrW'(ctx_f.n);
    count_d = count_q + (proc_go ? CntW'(ctx_f.n) : CntW'(0)) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_go) begin
      if (ctx_f.n != 2'd0) res_mem_q[tail_q]   <= ctx_f.r0;
      if (ctx_f.n == 2'd2) res_mem_q[tail_nxt] <= ctx_f.r1;
    end
  end

  assign head_res       = res_mem_q[head_q];
  assign out_valid_o    = (count_q != '0);
  assign color_o        = head_res.color;
  assign is_error_o     = head_res.is_error;
  assign last_of_item_o = head_res.last;

  if (PosW < xsc_pkg::PosPortBits) begin : g_pos_ext
    assign position_o = {{(xsc_pkg::PosPortBits - PosW){1'b0}}, head_res.position};
  end else begin : g_pos_full
    assign position_o = head_res.position;
  end

endmodule
`default_nettype wire

>>> tb/xsc_color_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsc_color_checker: prediction and compare for the XML syntax color lexer
// Follows every accepted character beat with a model of the lexer of its own.
// Each accepted color event is compared with the oldest predicted one.
// ----------------------------------------------------------------------------
module xsc_color_checker
  import xsc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic                   in_stall_i,
  input  wire logic [CharBits-1:0]    char_code_i,
  input  wire logic [OffsetBits-1:0]  char_offset_i,
  input  wire logic                   out_valid_i,
  input  wire logic                   out_stall_i,
  input  wire logic [1:0]             color_i,
  input  wire logic [PosPortBits-1:0] position_i,
  input  wire logic                   is_error_i,
  input  wire logic                   last_of_item_i,
  output int                          mismatches_o,
  output int                          pending_o,
  output int                          checked_o,
  output int                          errors_seen_o
);

  localparam int ReportLimit = 10;
  localparam logic [47:0] CdataWord = "CDATA[";

  typedef logic [CharBits-1:0]   char_t;
  typedef logic [OffsetBits-1:0] offset_t;

  typedef enum logic [3:0] {
    LxText, LxOpen, LxBang, LxBangDash, LxCdataWord, LxComment, LxCdata,
    LxStopFirst, LxStopName, LxStopSpace, LxMarkup
  } lex_mode_e;

  typedef enum logic [2:0] {
    MkNameFirst, MkName, MkAttrSpace, MkAttrName, MkEquals, MkValueWait,
    MkValue, MkClose
  } markup_step_e;

  typedef struct packed {
    logic [1:0]             color;
    logic [PosPortBits-1:0] position;
    logic                   is_error;
    logic                   last;
  } color_event_t;

  lex_mode_e    lex_mode;
  markup_step_e mk_step;
  logic         in_pi;
  offset_t      tag_start;
  logic         single_quote;
  logic         saw_blank;
  logic [2:0]   progress;
  logic         halted;

  color_event_t step_ev [2];
  int           step_n;
  color_event_t pending_colors [$];

  int mismatch_cnt;
  int checked_cnt;
  int error_cnt;

  function automatic logic is_name_start(char_t c);
    return (c >= ChUpA && c <= ChUpZ) || (c >= ChLoA && c <= ChLoZ) ||
           c == ChUscore || c == ChColon;
  endfunction

  function automatic logic is_name_char(char_t c);
    return is_name_start(c) || (c >= ChDig0 && c <= ChDig9) || c == ChDash;
  endfunction

  function automatic logic is_blank(char_t c);
    return c == ChSpace || c == ChTab || c == ChLf || c == ChCr;
  endfunction

  function automatic void emit(logic [1:0] color, offset_t pos, logic err);
    if (step_n < 2) begin
      step_ev[step_n] = {color, pos, err, 1'b0};
      step_n++;
    end
  endfunction

  function automatic void stop_at(offset_t off);
    emit(ColorText, off, 1'b1);
    halted   = 1'b1;
    lex_mode = LxText;
  endfunction

  // inside a tag or an instruction; returns 1 when the char must be rerun
  function automatic bit markup_char(char_t c, offset_t off);
    case (mk_step)
      MkNameFirst: begin
        if (is_name_start(c)) mk_step = MkName;
        else stop_at(off);
      end
      MkName, MkAttrName: begin
        if (is_name_char(c)) return 1'b0;
        if (mk_step == MkName) begin
          saw_blank = 1'b0;
          mk_step   = MkAttrSpace;
        end else begin
          mk_step = MkEquals;
        end
        return 1'b1;
      end
      MkAttrSpace: begin
        if (is_blank(c)) saw_blank = 1'b1;
        else if (in_pi && c == ChQuest) mk_step = MkClose;
        else if (!in_pi && c == ChSlash) mk_step = MkClose;
        else if (!in_pi && c == ChGt) begin
          emit(ColorText, off + 1, 1'b0);
          lex_mode = LxText;
        end else if (c != ChEnd && saw_blank && is_name_start(c)) mk_step = MkAttrName;
        else stop_at(off);
      end
      MkEquals: begin
        if (c == ChEq) mk_step = MkValueWait;
        else if (!is_blank(c)) stop_at(off);
      end
      MkValueWait: begin
        if (c == ChDquote || c == ChSquote) begin
          emit(ColorValue, off, 1'b0);
          single_quote = (c == ChSquote);
          mk_step      = MkValue;
        end else if (!is_blank(c)) begin
          stop_at(off);
        end
      end
      MkValue: begin
        if (c == (single_quote ? ChSquote : ChDquote)) begin
          emit(ColorMarkup, off + 1, 1'b0);
          saw_blank = 1'b0;
          mk_step   = MkAttrSpace;
        end else if (c == ChEnd) begin
          stop_at(off);
        end
      end
      default: begin
        if (c == ChGt) begin
          emit(ColorText, off + 1, 1'b0);
          lex_mode = LxText;
        end else begin
          stop_at(off);
        end
      end
    endcase
    return 1'b0;
  endfunction

  function automatic bit advance(char_t c, offset_t off);
    case (lex_mode)
      LxOpen: begin
        if (c == ChBang) begin
          lex_mode = LxBang;
        end else begin
          emit(ColorMarkup, tag_start, 1'b0);
          if (c == ChSlash) begin
            lex_mode = LxStopFirst;
          end else begin
            lex_mode = LxMarkup;
            mk_step  = MkNameFirst;
            in_pi    = (c == ChQuest);
            return c != ChQuest;
          end
        end
      end
      LxBang: begin
        if (c == ChDash) lex_mode = LxBangDash;
        else if (c == ChLbrack) begin
          lex_mode = LxCdataWord;
          progress = '0;
        end else stop_at(off);
      end
      LxBangDash: begin
        if (c == ChDash) begin
          emit(ColorComment, tag_start, 1'b0);
          lex_mode = LxComment;
          progress = '0;
        end else begin
          stop_at(off);
        end
      end
      LxCdataWord: begin
        if (progress > CdataLastIdx || c != char_t'(CdataWord[47 - 8*progress -: 8])) begin
          stop_at(off);
        end else if (progress == CdataLastIdx) begin
          emit(ColorMarkup, tag_start, 1'b0);
          emit(ColorText, off + 1, 1'b0);
          lex_mode = LxCdata;
          progress = '0;
        end else begin
          progress++;
        end
      end
      LxComment, LxCdata: begin
        if (c == ChEnd) begin
          emit(ColorText, off, 1'b0);
          lex_mode = LxText;
        end else if (c == (lex_mode == LxComment ? ChDash : ChRbrack)) begin
          if (progress < 2) progress++;
        end else if (c == ChGt && progress >= 2) begin
          // CDATA recolors its closing brackets as markup
          if (lex_mode == LxCdata) emit(ColorMarkup, off - 2, 1'b0);
          emit(ColorText, off + 1, 1'b0);
          lex_mode = LxText;
          progress = '0;
        end else begin
          progress = '0;
        end
      end
      LxStopFirst: begin
        if (is_name_start(c)) lex_mode = LxStopName;
        else stop_at(off);
      end
      LxStopName: begin
        if (is_name_char(c)) return 1'b0;
        lex_mode = LxStopSpace;
        return 1'b1;
      end
      LxStopSpace: begin
        if (c == ChGt) begin
          emit(ColorText, off + 1, 1'b0);
          lex_mode = LxText;
        end else if (!is_blank(c)) begin
          stop_at(off);
        end
      end
      LxMarkup: return markup_char(c, off);
      default: begin
        if (c == ChLt) begin
          tag_start = off;
          lex_mode  = LxOpen;
        end
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void lex_char(char_t c, offset_t off);
    step_n = 0;
    if (!halted) begin
      for (int r = 0; r < 4; r++) begin
        if (!advance(c, off) || halted) break;
      end
    end
    if (c == ChEnd) begin
      halted    = 1'b0;
      lex_mode  = LxText;
      progress  = '0;
      saw_blank = 1'b0;
    end
    if (step_n > 0) step_ev[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) pending_colors.push_back(step_ev[i]);
  endfunction

  function automatic void check_event();
    color_event_t got;
    color_event_t want;
    got = {color_i, position_i, is_error_i, last_of_item_i};
    checked_cnt++;
    if (is_error_i) error_cnt++;
    if (pending_colors.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= ReportLimit)
        $display("unexpected color event: color %0d pos %h err %0b last %0b",
                 got.color, got.position, got.is_error, got.last);
      return;
    end
    want = pending_colors.pop_front();
    if (got.color !== want.color || got.position !== want.position ||
        got.is_error !== want.is_error || got.last !== want.last) begin
      mismatch_cnt++;
      if (mismatch_cnt <= ReportLimit)
        $display("color event mismatch: expected color %0d pos %h err %0b last %0b, %s",
                 want.color, want.position, want.is_error, want.last,
                 $sformatf("got color %0d pos %h err %0b last %0b",
                           got.color, got.position, got.is_error, got.last));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lex_mode      = LxText;
      mk_step       = MkNameFirst;
      in_pi         = 1'b0;
      tag_start     = '0;
      single_quote  = 1'b0;
      saw_blank     = 1'b0;
      progress      = '0;
      halted        = 1'b0;
      mismatch_cnt  = 0;
      checked_cnt   = 0;
      error_cnt     = 0;
      pending_colors.delete();
      mismatches_o  <= 0;
      pending_o     <= 0;
      checked_o     <= 0;
      errors_seen_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) lex_char(char_code_i, char_offset_i);
      if (out_valid_i && !out_stall_i) check_event();
      mismatches_o  <= mismatch_cnt;
      pending_o     <= pending_colors.size();
      checked_o     <= checked_cnt;
      errors_seen_o <= error_cnt;
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: character stream stimulus for the XML syntax color lexer
// Drives a directed burst of markup corner cases, then random XML fragments
// (mostly well formed, some corrupted or cut short) with random idles and
// output stalls; the checker beside the block predicts and compares events.
// ----------------------------------------------------------------------------
module testbench;
  import xsc_pkg::*;

  typedef logic [CharBits-1:0]   char_t;
  typedef logic [OffsetBits-1:0] offset_t;

  // run shape
  localparam int RandomItems = 1250;
  localparam int IdlePct     = 28;
  localparam int TxCalmFrom  = 500;   // beats sent without any input idle
  localparam int TxCalmTo    = 700;
  localparam int HoldStart   = 700;   // receiver cycle where the hold-off starts
  localparam int HoldLen     = 400;
  localparam int RxCalmFrom  = 1300;  // receiver cycles without any stall
  localparam int RxCalmTo    = 1600;
  localparam int QuietLimit  = 3000;  // cycles with no beat before giving up
  localparam int DrainCycles = 16;

  localparam char_t MaxCode = 21'h10FFFF;

  // markup punctuation that the random noise draws from
  localparam char_t Specials [15] = '{
    ChLt, ChGt, ChSlash, ChQuest, ChBang, ChDash, ChLbrack, ChRbrack,
    ChEq, ChDquote, ChSquote, ChUscore, ChColon, ChEnd, ChSpace
  };

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_stall_i = 1'b0;
  char_t   char_code_i   = '0;
  offset_t char_offset_i = '0;

  logic                   in_stall_o;
  logic                   out_valid_o;
  logic [1:0]             color_o;
  logic [PosPortBits-1:0] position_o;
  logic                   is_error_o;
  logic                   last_of_item_o;

  int mismatches;
  int pending;
  int checked;
  int error_events;

  int      items_sent   = 0;
  int      quiet_cycles = 0;
  int      rx_cycle     = 0;
  offset_t next_offset  = '0;
  char_t   char_q [$];    // characters of the fragment being sent

  xml_syntax_color_lexer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .char_offset_i  (char_offset_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .color_o        (color_o),
    .position_o     (position_o),
    .is_error_o     (is_error_o),
    .last_of_item_o (last_of_item_o)
  );

  xsc_color_checker color_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .char_code_i    (char_code_i),
    .char_offset_i  (char_offset_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .color_i        (color_o),
    .position_i     (position_o),
    .is_error_i     (is_error_o),
    .last_of_item_i (last_of_item_o),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .checked_o      (checked),
    .errors_seen_o  (error_events)
  );

  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // character pickers
  // --------------------------------------------------------------------------
  function automatic char_t rand_letter();
    if ($urandom_range(0, 1)) return ChUpA + char_t'($urandom_range(0, 25));
    return ChLoA + char_t'($urandom_range(0, 25));
  endfunction

  function automatic char_t rand_name_start();
    case ($urandom_range(0, 9))
      0:       return ChUscore;
      1:       return ChColon;
      default: return rand_letter();
    endcase
  endfunction

  function automatic char_t rand_name_char();
    case ($urandom_range(0, 9))
      0:       return ChDig0 + char_t'($urandom_range(0, 9));
      1:       return ChDash;
      default: return rand_name_start();
    endcase
  endfunction

  function automatic char_t rand_blank();
    case ($urandom_range(0, 3))
      0:       return ChTab;
      1:       return ChLf;
      2:       return ChCr;
      default: return ChSpace;
    endcase
  endfunction

  // anything at all: punctuation, end of text, letters, any code point
  function automatic char_t rand_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return Specials[$urandom_range(0, 14)];
      4:          return ChEnd;
      5:          return rand_letter();
      6:          return ChDig0 + char_t'($urandom_range(0, 9));
      7:          return rand_blank();
      8:          return char_t'($urandom_range(0, MaxCode));
      default:    return MaxCode - char_t'($urandom_range(0, 3));
    endcase
  endfunction

  // offsets advance by the UTF-8 length of each character
  function automatic int utf8_len(char_t c);
    if (c < 21'h80) return 1;
    if (c < 21'h800) return 2;
    if (c < 21'h10000) return 3;
    return 4;
  endfunction

  // --------------------------------------------------------------------------
  // fragment builders, all appending to char_q
  // --------------------------------------------------------------------------
  function automatic void push_char(char_t c);
    char_q.push_back(c);
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) push_char(char_t'(s[i]));
  endfunction

  function automatic void push_blanks(int lo, int hi);
    repeat ($urandom_range(lo, hi)) push_char(rand_blank());
  endfunction

  function automatic void push_name();
    push_char(rand_name_start());
    repeat ($urandom_range(0, 5)) push_char(rand_name_char());
  endfunction

  // quoted value; content may hold the other quote, markup and blanks
  function automatic void push_value();
    char_t quote;
    char_t c;
    quote = $urandom_range(0, 1) ? ChSquote : ChDquote;
    push_char(quote);
    repeat ($urandom_range(0, 6)) begin
      c = rand_char();
      if (c == quote || c == ChEnd) c = rand_letter();
      push_char(c);
    end
    // blanks right before the closing quote must not eat it
    if ($urandom_range(0, 3) == 0) push_blanks(1, 2);
    push_char(quote);
  endfunction

  function automatic void push_attrs();
    repeat ($urandom_range(0, 3)) begin
      push_blanks(1, 2);
      push_name();
      push_blanks(0, 1);
      push_char(ChEq);
      push_blanks(0, 1);
      push_value();
    end
    push_blanks(0, 1);
  endfunction

  // body of a comment or CDATA section, rich in its closing character
  function automatic void push_body(char_t closer);
    char_t c;
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 5))
        0, 1:    c = closer;
        2:       c = ChGt;
        3:       c = rand_letter();
        default: c = rand_char();
      endcase
      push_char(c);
    end
  endfunction

  function automatic void build_fragment();
    int kind;
    int cut;
    int keep;
    // occasional jumps in offset, some right below the wrap point
    cut = $urandom_range(0, 99);
    if (cut < 3) next_offset = $urandom();
    else if (cut < 5) next_offset = 32'hFFFF_FFF8;

    kind = $urandom_range(0, 19);
    if (kind < 3) begin
      repeat ($urandom_range(1, 6))
        push_char($urandom_range(0, 2) ? rand_letter() : rand_char());
    end else if (kind < 8) begin
      push_char(ChLt);
      push_name();
      push_attrs();
      if ($urandom_range(0, 1)) push_char(ChSlash);
      push_char(ChGt);
    end else if (kind < 10) begin
      push_str("</");
      push_name();
      push_blanks(0, 2);
      push_char(ChGt);
    end else if (kind < 12) begin
      push_str("<?");
      push_name();
      push_attrs();
      push_str("?>");
    end else if (kind < 14) begin
      push_str("<!--");
      push_body(ChDash);
      push_str($urandom_range(0, 3) ? "-->" : "--->");
    end else if (kind < 16) begin
      push_str("<![CDATA[");
      push_body(ChRbrack);
      push_str($urandom_range(0, 3) ? "]]>" : "]]]>");
    end else if (kind < 18) begin
      push_char(ChEnd);
    end else begin
      repeat ($urandom_range(1, 6)) push_char(rand_char());
    end

    // a share of fragments gets one wrong character or is cut short
    cut = $urandom_range(0, 99);
    if (cut < 10) begin
      char_q[$urandom_range(0, char_q.size() - 1)] = rand_char();
    end else if (cut < 16) begin
      keep = $urandom_range(1, char_q.size());
      while (char_q.size() > keep) void'(char_q.pop_back());
      push_char(ChEnd);
    end
  endfunction

  // --------------------------------------------------------------------------
  // input side: one beat per character, valid held until accepted
  // --------------------------------------------------------------------------
  task automatic send_char(char_t c);
    while (!(items_sent >= TxCalmFrom && items_sent < TxCalmTo) &&
           $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    char_code_i   <= c;
    char_offset_i <= next_offset;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    next_offset += offset_t'(utf8_len(c));
    items_sent++;
  endtask

  task automatic send_queue();
    while (char_q.size() > 0) send_char(char_q.pop_front());
  endtask

  // --------------------------------------------------------------------------
  // output side: random stalls, one calm window and one long hold-off that
  // backs the block up into its input while the sender keeps offering
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle >= HoldStart && rx_cycle < HoldStart + HoldLen)
        out_stall_i <= 1'b1;
      else if (rx_cycle >= RxCalmFrom && rx_cycle < RxCalmTo)
        out_stall_i <= 1'b0;
      else
        out_stall_i <= ($urandom_range(0, 99) < IdlePct);
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: cycles in a row with no beat on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("timeout: no beat for %0d cycles, %0d events still due", QuietLimit, pending);
    $display("testbench NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: tag opened then text ends (color plus error in one beat),
    // "<!-->" that must not close the comment, then the real "-->"
    next_offset = '0;
    push_char(ChLt);
    push_char(ChEnd);
    push_str("<!-->-->");
    send_queue();
    // CDATA closed by "]]]>" with the '>' on the last offset, so the color
    // after it wraps to zero; then the top code point and end of text
    next_offset = 32'hFFFF_FFF3;
    push_str("<![CDATA[]]]>");
    push_char(MaxCode);
    push_char(ChEnd);
    send_queue();

    // random fragments
    while (items_sent < RandomItems) begin
      build_fragment();
      send_queue();
    end
    in_valid_i <= 1'b0;

    // drain: the checker's pending count is a registered copy
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("ran %0d characters through tags, instructions, comments and CDATA;",
             items_sent);
    $display("checked %0d color events (%0d error events) under idles and stalls",
             checked, error_events);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches, %0d events never seen", mismatches, pending);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/xsc_pkg.sv
rtl/xml_syntax_color_lexer.sv
tb/xsc_color_checker.sv
tb/testbench.sv
